FILE: sv/bmms_pkg.sv
// ============================================================================
// bmms_pkg: shared definitions for the block matching motion search
// Default geometry, port field widths, request codes and sequencer states.
// ============================================================================
package bmms_pkg;

    // default geometry
    localparam int BLOCK_DEF = 16;
    localparam int RANGE_DEF = 16;

    // port field widths
    localparam int REQ_W   = 2;
    localparam int POS_W   = 6;
    localparam int PIX_W   = 8;
    localparam int SAD_W   = 16;
    localparam int VEC_W   = 5;
    localparam int IN_W    = 24;   // row, col, pixel, at_top, at_bottom, at_left, at_right
    localparam int OUT_W   = 32;   // best_sad, vec_x, vec_y, zero fill

    localparam logic [SAD_W-1:0] SAD_NONE = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_CUR = 2'd0,
        REQ_LOAD_REF = 2'd1,
        REQ_SEARCH   = 2'd2
    } req_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SAD   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_NEXT  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

FILE: sv/bmms_ram.sv
// ============================================================================
// bmms_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ============================================================================
module bmms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/block_match_motion_search_top.sv
// ============================================================================
// block_match_motion_search_top: full-search SAD block matcher
// Loads fill a BLOCK x BLOCK current block and a WIN x WIN reference window,
// then a search beat scores every allowed displacement and returns the best.
// ============================================================================
//
//  channel  | dir | tdata (low bit up)                           | tuser
//  ---------+-----+----------------------------------------------+---------
//  s_       | in  | row[5:0] col[5:0] pixel[7:0] at_top at_bottom | req_type
//           |     | at_left at_right                             |
//  m_       | out | best_sad[15:0] vec_x[4:0] vec_y[4:0] 0[5:0]   | -
//
//  Load beats are accepted one per cycle while the sequencer is idle and may follow back to back.
//  A search walks one pixel per cycle through both RAM read ports:
//  each candidate is a read pass over the block, then a drain and a compare,
//  for up to (2*RANGE)^2 candidates, fewer when edge flags clip the range
//  or a zero sum stops the walk early.
//  s_tready is high only while the sequencer is idle; a pending result
//  does not block loads, only the end of the next search.
//  Reset clears the control state; the pixel stores are not cleared.
//
module block_match_motion_search_top #(
    parameter int BLOCK = bmms_pkg::BLOCK_DEF,
    parameter int RANGE = bmms_pkg::RANGE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // row, col, pixel, at_top, at_bottom, at_left, at_right
    input  logic [bmms_pkg::IN_W-1:0]    s_tdata,
    // req_type
    input  logic [bmms_pkg::REQ_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // best_sad, vec_x, vec_y, zero fill
    output logic [bmms_pkg::OUT_W-1:0]   m_tdata
);

    // geometry
    localparam int WIN      = BLOCK + 2 * RANGE - 1;
    localparam int BB       = BLOCK * BLOCK;
    localparam int CAW      = $clog2(BB);
    localparam int RAW      = $clog2(WIN * WIN);
    localparam int CNW      = $clog2(BLOCK);
    localparam int VW       = $clog2(RANGE + 1) + 1;
    localparam int AW       = $clog2(BB * 255 + 1);
    localparam int CMW      = (AW > bmms_pkg::SAD_W) ? AW : bmms_pkg::SAD_W;
    localparam int ZERO_OFS = RANGE * WIN + RANGE;
    localparam int TOP_OFS  = RANGE * WIN;
    localparam int ROW_SKIP = WIN - BLOCK + 1;

    localparam logic signed [VW-1:0] V_ZERO = '0;
    localparam logic signed [VW-1:0] V_ONE  = VW'(1);
    localparam logic signed [VW-1:0] V_NEG  = VW'(-RANGE);
    localparam logic signed [VW-1:0] V_POS  = VW'(RANGE);
    localparam logic [CNW-1:0]       CNT_LAST = CNW'(BLOCK - 1);

    // input field split
    logic [bmms_pkg::POS_W-1:0] in_row;
    logic [bmms_pkg::POS_W-1:0] in_col;
    logic [bmms_pkg::PIX_W-1:0] in_pixel;
    logic [3:0]                 in_edge;   // top, bottom, left, right
    bmms_pkg::req_t             in_req;
    logic                       in_beat;

    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_pixel = s_tdata[19:12];
    assign in_edge  = s_tdata[23:20];
    assign in_req   = bmms_pkg::req_t'(s_tuser);

    // sequencer and datapath registers
    bmms_pkg::state_t          state_reg, state_next;
    logic [CAW-1:0]            cur_addr_reg, cur_addr_next;
    logic [RAW-1:0]            ref_addr_reg, ref_addr_next;
    logic [CNW-1:0]            col_cnt_reg, col_cnt_next;
    logic [CNW-1:0]            row_cnt_reg, row_cnt_next;
    logic                      rd_pend_reg;
    logic [AW-1:0]             acc_reg, acc_next;
    logic [bmms_pkg::SAD_W-1:0] best_reg, best_next;
    logic signed [VW-1:0]      bx_reg, bx_next, by_reg, by_next;
    logic signed [VW-1:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic [RAW-1:0]            cand_base_reg, cand_base_next;
    logic [RAW-1:0]            row_base_reg, row_base_next;
    logic [3:0]                edge_reg, edge_next;
    logic                      is_zero_reg, is_zero_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [bmms_pkg::SAD_W-1:0] out_sad_reg, out_sad_next;
    logic [bmms_pkg::VEC_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;

    // RAM ports
    logic                       cur_we, ref_we;
    logic [CAW-1:0]             cur_waddr;
    logic [RAW-1:0]             ref_waddr;
    logic [bmms_pkg::PIX_W-1:0] cur_q, ref_q, abs_diff;

    assign s_tready = (state_reg == bmms_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    assign cur_we = in_beat && (in_req == bmms_pkg::REQ_LOAD_CUR)
                    && (32'(in_row) < BLOCK) && (32'(in_col) < BLOCK);
    assign ref_we = in_beat && (in_req == bmms_pkg::REQ_LOAD_REF)
                    && (32'(in_row) < WIN) && (32'(in_col) < WIN);
    assign cur_waddr = CAW'(32'(in_row) * BLOCK + 32'(in_col));
    assign ref_waddr = RAW'(32'(in_row) * WIN + 32'(in_col));

    bmms_ram #(
        .WIDTH (bmms_pkg::PIX_W),
        .DEPTH (BB)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (in_pixel),
        .raddr (cur_addr_reg),
        .rdata (cur_q)
    );

    bmms_ram #(
        .WIDTH (bmms_pkg::PIX_W),
        .DEPTH (WIN * WIN)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (in_pixel),
        .raddr (ref_addr_reg),
        .rdata (ref_q)
    );

    assign abs_diff = (cur_q > ref_q) ? (cur_q - ref_q) : (ref_q - cur_q);

    // search range from the edge flags latched at search start
    logic signed [VW-1:0] lo_y, hi_y, lo_x, hi_x;
    logic                 range_empty;
    logic [RAW-1:0]       first_base;

    assign lo_y = edge_reg[0] ? V_ZERO : V_NEG;
    assign hi_y = edge_reg[1] ? V_ZERO : V_POS;
    assign lo_x = edge_reg[2] ? V_ZERO : V_NEG;
    assign hi_x = edge_reg[3] ? V_ZERO : V_POS;
    assign range_empty = (edge_reg[0] && edge_reg[1]) || (edge_reg[2] && edge_reg[3]);
    // window address of the first raster candidate
    assign first_base = RAW'((edge_reg[0] ? TOP_OFS : 0) + (edge_reg[2] ? RANGE : 0));

    // compare of the finished sum against the running best
    logic                       cand_better;
    logic [bmms_pkg::SAD_W-1:0] best_upd;

    assign cand_better = CMW'(acc_reg) < CMW'(best_reg);
    assign best_upd    = cand_better ? bmms_pkg::SAD_W'(acc_reg) : best_reg;

    // raster step to the following offset
    logic signed [VW-1:0] x_inc, y_inc;
    logic                 x_wrap, walk_done, step_zero;
    logic signed [VW-1:0] step_x, step_y;

    assign x_inc     = cx_reg + V_ONE;
    assign y_inc     = cy_reg + V_ONE;
    assign x_wrap    = !(x_inc < hi_x);
    assign walk_done = x_wrap && !(y_inc < hi_y);
    assign step_x    = x_wrap ? lo_x : x_inc;
    assign step_y    = x_wrap ? y_inc : cy_reg;
    assign step_zero = (step_x == V_ZERO) && (step_y == V_ZERO);

    always_comb
    begin
        state_next     = state_reg;
        cur_addr_next  = cur_addr_reg;
        ref_addr_next  = ref_addr_reg;
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cand_base_next = cand_base_reg;
        row_base_next  = row_base_reg;
        edge_next      = edge_reg;
        is_zero_next   = is_zero_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_sad_next   = out_sad_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // sum lags the address by the RAM read latency
        if (rd_pend_reg)
        begin
            acc_next = acc_reg + AW'(abs_diff);
        end

        case (state_reg)
            bmms_pkg::ST_IDLE:
            begin
                if (in_beat && (in_req == bmms_pkg::REQ_SEARCH))
                begin
                    edge_next     = in_edge;
                    best_next     = bmms_pkg::SAD_NONE;
                    bx_next       = V_ZERO;
                    by_next       = V_ZERO;
                    is_zero_next  = 1'b1;
                    cur_addr_next = '0;
                    ref_addr_next = RAW'(ZERO_OFS);
                    col_cnt_next  = '0;
                    row_cnt_next  = '0;
                    acc_next      = '0;
                    state_next    = bmms_pkg::ST_SAD;
                end
            end

            bmms_pkg::ST_SAD:
            begin
                cur_addr_next = cur_addr_reg + CAW'(1);
                if (col_cnt_reg == CNT_LAST)
                begin
                    col_cnt_next  = '0;
                    row_cnt_next  = row_cnt_reg + CNW'(1);
                    ref_addr_next = ref_addr_reg + RAW'(ROW_SKIP);
                    if (row_cnt_reg == CNT_LAST)
                    begin
                        state_next = bmms_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    col_cnt_next  = col_cnt_reg + CNW'(1);
                    ref_addr_next = ref_addr_reg + RAW'(1);
                end
            end

            bmms_pkg::ST_DRAIN:
            begin
                state_next = bmms_pkg::ST_CHECK;
            end

            bmms_pkg::ST_CHECK:
            begin
                best_next    = best_upd;
                is_zero_next = 1'b0;
                if (cand_better)
                begin
                    bx_next = cx_reg;
                    by_next = cy_reg;
                end
                if (is_zero_reg)
                begin
                    bx_next = V_ZERO;
                    by_next = V_ZERO;
                end
                if (best_upd == '0)
                begin
                    state_next = bmms_pkg::ST_OUT;
                end
                else if (is_zero_reg)
                begin
                    // move to the first raster offset
                    cx_next        = lo_x;
                    cy_next        = lo_y;
                    row_base_next  = first_base;
                    cand_base_next = first_base;
                    cur_addr_next  = '0;
                    ref_addr_next  = first_base;
                    col_cnt_next   = '0;
                    row_cnt_next   = '0;
                    acc_next       = '0;
                    if (range_empty)
                    begin
                        state_next = bmms_pkg::ST_OUT;
                    end
                    else if ((lo_x == V_ZERO) && (lo_y == V_ZERO))
                    begin
                        state_next = bmms_pkg::ST_NEXT;
                    end
                    else
                    begin
                        state_next = bmms_pkg::ST_SAD;
                    end
                end
                else
                begin
                    state_next = bmms_pkg::ST_NEXT;
                end
            end

            bmms_pkg::ST_NEXT:
            begin
                if (walk_done)
                begin
                    state_next = bmms_pkg::ST_OUT;
                end
                else
                begin
                    cx_next = step_x;
                    cy_next = step_y;
                    if (x_wrap)
                    begin
                        row_base_next  = row_base_reg + RAW'(WIN);
                        cand_base_next = row_base_reg + RAW'(WIN);
                    end
                    else
                    begin
                        cand_base_next = cand_base_reg + RAW'(1);
                    end
                    cur_addr_next = '0;
                    ref_addr_next = cand_base_next;
                    col_cnt_next  = '0;
                    row_cnt_next  = '0;
                    acc_next      = '0;
                    // zero vector was scored first: step over it
                    if (!step_zero)
                    begin
                        state_next = bmms_pkg::ST_SAD;
                    end
                end
            end

            bmms_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_sad_next  = best_reg;
                    out_x_next    = bmms_pkg::VEC_W'(bx_reg);
                    out_y_next    = bmms_pkg::VEC_W'(by_reg);
                    state_next    = bmms_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bmms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bmms_pkg::ST_IDLE;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_pend_reg  <= (state_reg == bmms_pkg::ST_SAD);
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_addr_reg  <= cur_addr_next;
        ref_addr_reg  <= ref_addr_next;
        col_cnt_reg   <= col_cnt_next;
        row_cnt_reg   <= row_cnt_next;
        acc_reg       <= acc_next;
        best_reg      <= best_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cand_base_reg <= cand_base_next;
        row_base_reg  <= row_base_next;
        edge_reg      <= edge_next;
        is_zero_reg   <= is_zero_next;
        out_sad_reg   <= out_sad_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_y_reg, out_x_reg, out_sad_reg};

endmodule
